FILE: rtl/core/cfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfp_pkg;

   localparam logic [7:0] HDR_FIRST      = 8'hAA;
   localparam logic [7:0] HDR_SECOND     = 8'h55;

   localparam logic [7:0] CMD_MOVE       = 8'h01;
   localparam logic [7:0] CMD_ESTOP      = 8'h02;
   localparam logic [7:0] CMD_CLEAR      = 8'h03;
   localparam logic [7:0] CMD_DEBUG_PAGE = 8'h04;
   localparam logic [7:0] CMD_MAIN_PAGE  = 8'h05;

   localparam logic [1:0] STATUS_NONE    = 2'd0;
   localparam logic [1:0] STATUS_ENTER   = 2'd1;
   localparam logic [1:0] STATUS_LEAVE   = 2'd2;

   localparam int PAYLOAD_BYTES = 4;

   // one classified byte handed from the parser to the command stage
   typedef struct packed {
      logic               frame_done;
      logic               checksum_bad;
      logic [7:0]         command_id;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
   } cfp_work_type;

endpackage

`default_nettype wire

FILE: rtl/core/cfp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_front
   import cfp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_rx_byte,
   output logic              work_valid,
   input  wire logic         work_ready,
   output cfp_work_type      work_data
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_HDR2    = 3'd1;
   localparam logic [2:0] PH_ID      = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CHECK   = 3'd4;

   logic [2:0] phase_ff, phase_in;
   logic [7:0] frame_id_ff, frame_id_in;
   logic [2:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] payload_ff [PAYLOAD_BYTES];
   logic       take;
   logic [2:0] count_next;

   assign req_ready  = work_ready;
   assign work_valid = req_valid;
   assign take       = req_valid && work_ready;
   assign count_next = count_ff + 3'd1;

   always_comb begin
      phase_in    = phase_ff;
      frame_id_in = frame_id_ff;
      count_in    = count_ff;
      sum_in      = sum_ff;
      work_data   = '0;
      unique case (phase_ff)
         PH_HDR2: begin
            phase_in = (req_rx_byte == HDR_SECOND) ? PH_ID : PH_HUNT;
         end
         PH_ID: begin
            frame_id_in = req_rx_byte;
            sum_in      = req_rx_byte;
            count_in    = 3'd0;
            phase_in    = (req_rx_byte == CMD_MOVE) ? PH_PAYLOAD : PH_CHECK;
         end
         PH_PAYLOAD: begin
            count_in = count_next;
            sum_in   = sum_ff + req_rx_byte;
            if (count_next >= 3'(PAYLOAD_BYTES)) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            work_data.frame_done   = 1'b1;
            work_data.checksum_bad = (sum_ff != req_rx_byte);
            work_data.command_id   = frame_id_ff;
            work_data.target_x     = {payload_ff[0], payload_ff[1]};
            work_data.target_y     = {payload_ff[2], payload_ff[3]};
            phase_in               = PH_HUNT;
         end
         default: begin
            // unused codes behave as hunting
            phase_in = (req_rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         frame_id_ff <= '0;
         count_ff    <= '0;
         sum_ff      <= '0;
      end else if (take) begin
         phase_ff    <= phase_in;
         frame_id_ff <= frame_id_in;
         count_ff    <= count_in;
         sum_ff      <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && phase_ff == PH_PAYLOAD) begin
         payload_ff[count_ff[1:0]] <= req_rx_byte;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/cfp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_queue
   import cfp_pkg::*;
#(
   parameter int Depth = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire cfp_work_type in_data,
   output logic              out_valid,
   input  wire logic         out_ready,
   output cfp_work_type      out_data
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cfp_work_type    entry_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push, pop;

   assign in_ready  = (count_ff != CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/cfp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfp_back
   import cfp_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          work_valid,
   output logic               work_ready,
   input  wire cfp_work_type  work_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_frame_done,
   output logic               rsp_checksum_bad,
   output logic [7:0]         rsp_command_id,
   output logic               rsp_move_request,
   output logic signed [15:0] rsp_target_x,
   output logic signed [15:0] rsp_target_y,
   output logic               rsp_stop_motors,
   output logic [1:0]         rsp_status_update,
   output logic               rsp_estop_active,
   output logic               rsp_page_changed,
   output logic               rsp_page_select
);

   logic               valid_ff;
   logic               estop_ff, estop_in;
   logic               page_ff, page_in;
   logic               take;

   logic               done_ff, bad_ff, move_ff, stop_ff, pchg_ff;
   logic               move_in, stop_in, pchg_in;
   logic [7:0]         id_ff;
   logic signed [15:0] tx_ff, ty_ff, tx_in, ty_in;
   logic [1:0]         status_ff, status_in;

   assign work_ready = !valid_ff || rsp_ready;
   assign take       = work_valid && work_ready;

   always_comb begin
      estop_in  = estop_ff;
      page_in   = page_ff;
      move_in   = 1'b0;
      stop_in   = 1'b0;
      pchg_in   = 1'b0;
      tx_in     = '0;
      ty_in     = '0;
      status_in = STATUS_NONE;
      if (work_data.frame_done && !work_data.checksum_bad) begin
         unique case (work_data.command_id)
            CMD_MOVE: begin
               if (!estop_ff) begin
                  move_in = 1'b1;
                  tx_in   = work_data.target_x;
                  ty_in   = work_data.target_y;
               end
            end
            CMD_ESTOP: begin
               estop_in  = 1'b1;
               stop_in   = 1'b1;
               status_in = STATUS_ENTER;
            end
            CMD_CLEAR: begin
               if (estop_ff) begin
                  estop_in  = 1'b0;
                  status_in = STATUS_LEAVE;
               end
               // targets stay zero
               move_in = 1'b1;
            end
            CMD_DEBUG_PAGE: begin
               page_in = 1'b1;
               pchg_in = 1'b1;
            end
            CMD_MAIN_PAGE: begin
               page_in = 1'b0;
               pchg_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         estop_ff <= 1'b0;
         page_ff  <= 1'b0;
      end else begin
         if (take) begin
            valid_ff <= 1'b1;
            estop_ff <= estop_in;
            page_ff  <= page_in;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         done_ff   <= work_data.frame_done;
         bad_ff    <= work_data.checksum_bad;
         id_ff     <= work_data.command_id;
         move_ff   <= move_in;
         tx_ff     <= tx_in;
         ty_ff     <= ty_in;
         stop_ff   <= stop_in;
         status_ff <= status_in;
         pchg_ff   <= pchg_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_frame_done    = done_ff;
   assign rsp_checksum_bad  = bad_ff;
   assign rsp_command_id    = id_ff;
   assign rsp_move_request  = move_ff;
   assign rsp_target_x      = tx_ff;
   assign rsp_target_y      = ty_ff;
   assign rsp_stop_motors   = stop_ff;
   assign rsp_status_update = status_ff;
   assign rsp_estop_active  = estop_ff;
   assign rsp_page_changed  = pchg_ff;
   assign rsp_page_select   = page_ff;

endmodule

`default_nettype wire

FILE: rtl/core/command_frame_parser_core.sv
// channel   direction  handshake            payload
// req_      in         req_valid/req_ready  rx_byte[7:0]
// rsp_      out        rsp_valid/rsp_ready  frame_done .. page_select, one item per byte
//
// one byte accepted per cycle while req_ready is high; each byte yields exactly one result item
// path: parser into a queue (two entries by default), command stage into the output register
// req_ready drops only when the queue is full (two items by default); in a full stream the
// queue holds one, so req_ready falls the cycle after the first cycle of rsp_ready low
// reset is synchronous: parser hunts for the header, stop latch and page return to zero
`timescale 1ns / 1ps
`default_nettype none

module command_frame_parser_core
   import cfp_pkg::*;
#(
   parameter int QueueDepth = 2
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire logic [7:0]    req_rx_byte,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_frame_done,
   output logic               rsp_checksum_bad,
   output logic [7:0]         rsp_command_id,
   output logic               rsp_move_request,
   output logic signed [15:0] rsp_target_x,
   output logic signed [15:0] rsp_target_y,
   output logic               rsp_stop_motors,
   output logic [1:0]         rsp_status_update,
   output logic               rsp_estop_active,
   output logic               rsp_page_changed,
   output logic               rsp_page_select
);

   logic         fq_valid, fq_ready;
   cfp_work_type fq_data;
   logic         qb_valid, qb_ready;
   cfp_work_type qb_data;

   cfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .work_valid  (fq_valid),
      .work_ready  (fq_ready),
      .work_data   (fq_data)
   );

   cfp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_data   (fq_data),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_data  (qb_data)
   );

   cfp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .work_valid        (qb_valid),
      .work_ready        (qb_ready),
      .work_data         (qb_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_checksum_bad  (rsp_checksum_bad),
      .rsp_command_id    (rsp_command_id),
      .rsp_move_request  (rsp_move_request),
      .rsp_target_x      (rsp_target_x),
      .rsp_target_y      (rsp_target_y),
      .rsp_stop_motors   (rsp_stop_motors),
      .rsp_status_update (rsp_status_update),
      .rsp_estop_active  (rsp_estop_active),
      .rsp_page_changed  (rsp_page_changed),
      .rsp_page_select   (rsp_page_select)
   );

   a_bad_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_bad |-> rsp_frame_done)
      else $error("checksum_bad without frame_done");

   a_move_needs_good_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_move_request |-> rsp_frame_done && !rsp_checksum_bad && !rsp_estop_active)
      else $error("move request outside a good frame or while stopped");

   a_stop_sets_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stop_motors |-> rsp_estop_active && rsp_status_update == STATUS_ENTER)
      else $error("stop pulse without latched emergency stop");

   a_leave_clears_latch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status_update == STATUS_LEAVE |-> !rsp_estop_active && rsp_move_request)
      else $error("leave status with latch still set");

endmodule

`default_nettype wire

FILE: tb/command_frame_parser_core_tb.sv
`timescale 1ns / 1ps

module command_frame_parser_core_tb
   import cfp_pkg::*;
;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_SYNC,
      PH_ID,
      PH_PAYLOAD,
      PH_SUM
   } parse_phase_type;

   typedef struct packed {
      logic               frame_done;
      logic               checksum_bad;
      logic [7:0]         command_id;
      logic               move_request;
      logic signed [15:0] target_x;
      logic signed [15:0] target_y;
      logic               stop_motors;
      logic [1:0]         status_update;
      logic               estop_active;
      logic               page_changed;
      logic               page_select;
   } frame_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_frame_done;
   logic               rsp_checksum_bad;
   logic [7:0]         rsp_command_id;
   logic               rsp_move_request;
   logic signed [15:0] rsp_target_x;
   logic signed [15:0] rsp_target_y;
   logic               rsp_stop_motors;
   logic [1:0]         rsp_status_update;
   logic               rsp_estop_active;
   logic               rsp_page_changed;
   logic               rsp_page_select;

   // predictor state
   parse_phase_type parse_phase = PH_HUNT;
   logic [7:0]   frame_cmd = 8'h00;
   logic [7:0]   frame_sum = 8'h00;
   logic [7:0]   payload_bytes [0:3] = '{default: 8'h00};
   int           payload_idx = 0;
   logic         stop_latched = 1'b0;
   logic         page_is_debug = 1'b0;

   frame_result_type pending_results [$];
   int  mismatches = 0;
   int  bytes_sent = 0;
   int  frames_seen = 0;
   int  drops_seen = 0;
   int  moves_seen = 0;
   int  estops_seen = 0;
   bit  steady = 1'b0;

   command_frame_parser_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frame_done    (rsp_frame_done),
      .rsp_checksum_bad  (rsp_checksum_bad),
      .rsp_command_id    (rsp_command_id),
      .rsp_move_request  (rsp_move_request),
      .rsp_target_x      (rsp_target_x),
      .rsp_target_y      (rsp_target_y),
      .rsp_stop_motors   (rsp_stop_motors),
      .rsp_status_update (rsp_status_update),
      .rsp_estop_active  (rsp_estop_active),
      .rsp_page_changed  (rsp_page_changed),
      .rsp_page_select   (rsp_page_select)
   );

   always #2 clock = ~clock;

   function automatic frame_result_type parse_byte(input logic [7:0] b);
      frame_result_type r;
      r = '0;
      case (parse_phase)
         PH_SYNC: parse_phase = (b == HDR_SECOND) ? PH_ID : PH_HUNT;
         PH_ID: begin
            frame_cmd = b;
            frame_sum = b;
            payload_idx = 0;
            parse_phase = (b == CMD_MOVE) ? PH_PAYLOAD : PH_SUM;
         end
         PH_PAYLOAD: begin
            payload_bytes[payload_idx] = b;
            payload_idx++;
            frame_sum += b;
            if (payload_idx == PAYLOAD_BYTES) parse_phase = PH_SUM;
         end
         PH_SUM: begin
            r.frame_done = 1'b1;
            r.command_id = frame_cmd;
            if (frame_sum != b) begin
               r.checksum_bad = 1'b1;
            end else begin
               case (frame_cmd)
                  CMD_MOVE: begin
                     if (!stop_latched) begin
                        r.move_request = 1'b1;
                        r.target_x = {payload_bytes[0], payload_bytes[1]};
                        r.target_y = {payload_bytes[2], payload_bytes[3]};
                     end
                  end
                  CMD_ESTOP: begin
                     stop_latched = 1'b1;
                     r.stop_motors = 1'b1;
                     r.status_update = STATUS_ENTER;
                  end
                  CMD_CLEAR: begin
                     if (stop_latched) begin
                        stop_latched = 1'b0;
                        r.status_update = STATUS_LEAVE;
                     end
                     r.move_request = 1'b1;
                  end
                  CMD_DEBUG_PAGE: begin
                     page_is_debug = 1'b1;
                     r.page_changed = 1'b1;
                  end
                  CMD_MAIN_PAGE: begin
                     page_is_debug = 1'b0;
                     r.page_changed = 1'b1;
                  end
                  default: ;
               endcase
            end
            parse_phase = PH_HUNT;
         end
         default: parse_phase = (b == HDR_FIRST) ? PH_SYNC : PH_HUNT;
      endcase
      r.estop_active = stop_latched;
      r.page_select = page_is_debug;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= 27);
   end

   // predict on every accepted byte, check every accepted result item
   always @(posedge clock) begin
      frame_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) pending_results.push_back(parse_byte(req_rx_byte));
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               mismatches++;
               $display("%0t ns: result item with nothing expected, expected none, actual id 0x%0h",
                        $time, rsp_command_id);
            end else begin
               want = pending_results.pop_front();
               compare_field("frame_done", want.frame_done, rsp_frame_done);
               compare_field("checksum_bad", want.checksum_bad, rsp_checksum_bad);
               compare_field("command_id", want.command_id, rsp_command_id);
               compare_field("move_request", want.move_request, rsp_move_request);
               compare_field("target_x", want.target_x, rsp_target_x);
               compare_field("target_y", want.target_y, rsp_target_y);
               compare_field("stop_motors", want.stop_motors, rsp_stop_motors);
               compare_field("status_update", want.status_update, rsp_status_update);
               compare_field("estop_active", want.estop_active, rsp_estop_active);
               compare_field("page_changed", want.page_changed, rsp_page_changed);
               compare_field("page_select", want.page_select, rsp_page_select);
               if (want.frame_done) frames_seen++;
               if (want.checksum_bad) drops_seen++;
               if (want.move_request) moves_seen++;
               if (want.stop_motors) estops_seen++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] cmd, input logic [31:0] targets,
                             input bit corrupt);
      logic [7:0] sum;
      sum = cmd;
      send_byte(HDR_FIRST);
      send_byte(HDR_SECOND);
      send_byte(cmd);
      if (cmd == CMD_MOVE) begin
         for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            send_byte(targets[31 - 8 * i -: 8]);
            sum += targets[31 - 8 * i -: 8];
         end
      end
      if (corrupt) sum ^= 8'($urandom_range(255, 1));
      send_byte(sum);
   endtask

   function automatic logic [7:0] pick_command();
      int r;
      r = $urandom_range(99);
      if (r < 50) return CMD_MOVE;
      if (r < 58) return CMD_ESTOP;
      if (r < 70) return CMD_CLEAR;
      if (r < 78) return CMD_DEBUG_PAGE;
      if (r < 86) return CMD_MAIN_PAGE;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [15:0] pick_target();
      case ($urandom_range(7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_header_sync();
      // 0xAA followed by anything but 0x55 drops back to hunting
      send_byte(HDR_FIRST);
      send_byte(8'h12);
   endtask

   task automatic test_move_extremes();
      send_frame(CMD_MOVE, {16'h7FFF, 16'h8000}, 1'b0);
   endtask

   task automatic test_command_set();
      send_frame(CMD_ESTOP, '0, 1'b0);
      send_frame(CMD_CLEAR, '0, 1'b0);
      send_frame(CMD_DEBUG_PAGE, '0, 1'b1);
      send_frame(CMD_MAIN_PAGE, '0, 1'b0);
      send_frame(8'hFF, '0, 1'b0);
   endtask

   task automatic test_random_traffic(input int count);
      int first;
      int done;
      int r;
      first = bytes_sent;
      done = 0;
      while (done < count) begin
         steady = (done > count / 3) && (done < count / 2);
         r = $urandom_range(99);
         if (r < 75) begin
            send_frame(pick_command(), {pick_target(), pick_target()},
                       $urandom_range(9) == 0);
         end else if (r < 85) begin
            send_byte(HDR_FIRST);
            if ($urandom_range(1)) send_byte(HDR_FIRST);
            else send_byte(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
         end
         done = bytes_sent - first;
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_header_sync();
      test_move_extremes();
      test_command_set();
      test_random_traffic(1850);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d bytes: %0d frames, %0d dropped on checksum, %0d moves, %0d stops",
               bytes_sent, frames_seen, drops_seen, moves_seen, estops_seen);
      $display("random idling on both channels with one stretch at full rate");
      if (mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout waiting for the parser");
      $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/core/cfp_pkg.sv
rtl/core/cfp_front.sv
rtl/core/cfp_queue.sv
rtl/core/cfp_back.sv
rtl/core/command_frame_parser_core.sv
tb/command_frame_parser_core_tb.sv
